[hw/rtl/bla_pkg.sv]
package bla_pkg;

	// default sizes, handed down from the top level
	localparam int REQUESTERS_DEF  = 8;
	localparam int TICKET_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int CMD_W        = 2;
	localparam int REQ_W        = 3;
	localparam int OUT_TICKET_W = 16;

	// command codes; the unused code behaves as a poll
	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POLL    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture cmd and requester
		logic clear;      // clear scan counter and accumulators
		logic scan;       // read entry at scan counter, advance counter
		logic mode_max;   // scan looks for the largest ticket, else for conflicts
		logic rd_me;      // read the requester's own entry
		logic take_mine;  // own ticket from read data
		logic write_new;  // store new ticket, raise wanting flag
		logic clr_want;   // drop wanting flag
		logic out_load;   // capture result into output register
	} dp_ctrl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_range;
		logic is_acquire;
		logic is_release;
		logic cnt_last;
	} dp_stat_t;

endpackage

[hw/rtl/bakery_lock_arbiter.sv]
// an acquire scans for the largest ticket, writes its own and scans for conflicts, a
// poll reads its own entry and scans, a release reads its own entry only; the scans
// read one entry a cycle; one transaction at a time, the next one taken the cycle
// after the result is loaded
// reset: asynchronous, active low; clears all wanting flags and marks every
// ticket as zero through per-entry valid bits, no clearing pass
module bakery_lock_arbiter import bla_pkg::*; #(
	parameter int REQUESTERS  = REQUESTERS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [REQ_W-1:0]        requester,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    granted,
	output logic [OUT_TICKET_W-1:0] ticket,
	output logic                    ticket_overflow
);

	// command and status between sequencer and datapath
	dp_ctrl_t ctl;
	dp_stat_t stat;

	// sequencer: capture, largest-ticket scan, ticket write, conflict scan, result
	bla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath: ticket store, wanting flags, scan accumulators, output register
	// the output register lets a new transaction in while a result waits
	bla_dp #(
		.REQUESTERS  (REQUESTERS),
		.TICKET_BITS (TICKET_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.requester       (requester),
		.ctl             (ctl),
		.stat            (stat),
		.granted         (granted),
		.ticket          (ticket),
		.ticket_overflow (ticket_overflow)
	);

endmodule

[hw/rtl/bla_dp.sv]
module bla_dp import bla_pkg::*; #(
	parameter int REQUESTERS  = REQUESTERS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [REQ_W-1:0]        requester,
	input  dp_ctrl_t                ctl,
	output dp_stat_t                stat,
	output logic                    granted,
	output logic [OUT_TICKET_W-1:0] ticket,
	output logic                    ticket_overflow
);

	localparam int IDX_W = $clog2(REQUESTERS);
	localparam int CMP_W = (IDX_W > REQ_W) ? IDX_W : REQ_W;
	localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REQUESTERS - 1);

	logic [CMD_W-1:0]       cmd_q;
	logic [REQ_W-1:0]       me_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [TICKET_BITS-1:0] top_q;
	logic [TICKET_BITS-1:0] mine_q;
	logic                   conflict_q;
	logic                   ovf_q;
	logic [REQUESTERS-1:0]  wanting_q;
	logic [REQUESTERS-1:0]  tvld_q;

	logic [TICKET_BITS-1:0] tickets_mem [REQUESTERS];

	logic [TICKET_BITS-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic                   rd_want_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   scan_s1;
	logic                   mode_max_s1;

	logic                    granted_q;
	logic [OUT_TICKET_W-1:0] ticket_q;
	logic                    ovf_out_q;

	logic [IDX_W-1:0]       me_idx;
	logic [IDX_W-1:0]       rd_addr;
	logic                   rd_en;
	logic                   in_range;
	logic [TICKET_BITS-1:0] rd_val;
	logic                   ahead;
	logic [TICKET_BITS-1:0] new_ticket;
	logic                   top_sat;

	assign me_idx   = IDX_W'(me_q);
	assign in_range = 32'(me_q) < 32'(REQUESTERS);
	assign rd_addr  = ctl.rd_me ? me_idx : cnt_q;
	assign rd_en    = ctl.scan | ctl.rd_me;

	// an entry never written reads as zero
	assign rd_val = rd_vld_s1 ? rd_data_s1 : '0;

	// flagged entry with a smaller ticket, or equal ticket and smaller index
	assign ahead = rd_want_s1 && ((rd_val < mine_q) ||
		((rd_val == mine_q) && (CMP_W'(rd_idx_s1) < CMP_W'(me_q))));

	assign top_sat    = (top_q == TICKET_MAX);
	assign new_ticket = top_sat ? TICKET_MAX : top_q + 1'b1;

	assign stat.in_range   = in_range;
	assign stat.is_acquire = (cmd_q == CMD_ACQUIRE);
	assign stat.is_release = (cmd_q == CMD_RELEASE);
	assign stat.cnt_last   = (cnt_q == LAST_IDX);

	// ticket store and its registered read port
	always_ff @(posedge clk) begin
		if (ctl.write_new)
			tickets_mem[me_idx] <= new_ticket;
		if (rd_en) begin
			rd_data_s1 <= tickets_mem[rd_addr];
			rd_vld_s1  <= tvld_q[rd_addr];
			rd_want_s1 <= wanting_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanting_q   <= '0;
			tvld_q      <= '0;
			cnt_q       <= '0;
			scan_s1     <= 1'b0;
			mode_max_s1 <= 1'b0;
			top_q       <= '0;
			conflict_q  <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			scan_s1     <= ctl.scan;
			mode_max_s1 <= ctl.mode_max;
			if (ctl.write_new) begin
				wanting_q[me_idx] <= 1'b1;
				tvld_q[me_idx]    <= 1'b1;
			end else if (ctl.clr_want) begin
				wanting_q[me_idx] <= 1'b0;
			end
			if (ctl.load)
				ovf_q <= 1'b0;
			else if (ctl.write_new)
				ovf_q <= top_sat;
			if (ctl.clear) begin
				cnt_q      <= '0;
				top_q      <= '0;
				conflict_q <= 1'b0;
			end else begin
				if (ctl.scan)
					cnt_q <= cnt_q + 1'b1;
				if (scan_s1 && mode_max_s1 && (rd_val > top_q))
					top_q <= rd_val;
				if (scan_s1 && !mode_max_s1 && ahead)
					conflict_q <= 1'b1;
			end
		end
	end

	// captured request, own ticket and result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			me_q  <= requester;
		end
		if (ctl.write_new)
			mine_q <= new_ticket;
		else if (ctl.take_mine)
			mine_q <= rd_val;
		if (ctl.out_load) begin
			granted_q <= in_range && wanting_q[me_idx] && !conflict_q;
			ticket_q  <= in_range ? OUT_TICKET_W'(mine_q) : '0;
			ovf_out_q <= in_range && ovf_q;
		end
	end

	assign granted         = granted_q;
	assign ticket          = ticket_q;
	assign ticket_overflow = ovf_out_q;

endmodule

[hw/rtl/bla_ctrl.sv]
module bla_ctrl import bla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_ctrl_t ctl
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOOK = 4'd1;
	localparam logic [3:0] ST_WME  = 4'd2;
	localparam logic [3:0] ST_MAX  = 4'd3;
	localparam logic [3:0] ST_MAXW = 4'd4;
	localparam logic [3:0] ST_WR   = 4'd5;
	localparam logic [3:0] ST_GNT  = 4'd6;
	localparam logic [3:0] ST_GNTW = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!stat.in_range) begin
					state_d = ST_FIN;
				end else if (stat.is_acquire) begin
					ctl.clear = 1'b1;
					state_d   = ST_MAX;
				end else begin
					ctl.rd_me    = 1'b1;
					ctl.clr_want = stat.is_release;
					state_d      = ST_WME;
				end
			end
			ST_WME: begin
				ctl.take_mine = 1'b1;
				ctl.clear     = 1'b1;
				state_d       = stat.is_release ? ST_FIN : ST_GNT;
			end
			ST_MAX: begin
				ctl.scan     = 1'b1;
				ctl.mode_max = 1'b1;
				if (stat.cnt_last)
					state_d = ST_MAXW;
			end
			ST_MAXW: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				ctl.write_new = 1'b1;
				ctl.clear     = 1'b1;
				state_d       = ST_GNT;
			end
			ST_GNT: begin
				ctl.scan = 1'b1;
				if (stat.cnt_last)
					state_d = ST_GNTW;
			end
			ST_GNTW: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[test/tb_bakery_lock_arbiter.sv]
`timescale 1ns / 100ps

module tb_bakery_lock_arbiter;
	import bla_pkg::*;

	// sizes the testbench predicts for, same as the block's defaults
	localparam int REQ_COUNT = REQUESTERS_DEF;
	localparam int TICKET_W  = TICKET_BITS_DEF;
	localparam logic [TICKET_W-1:0] TICKET_TOP = '1;

	// code the block treats as a poll
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	// run shape
	localparam int RANDOM_ITEMS   = 1250;
	localparam int HOLD_AT_CYCLE  = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 2 * REQ_COUNT + 12;
	localparam int REPORT_LINES   = 30;

	// one expected result transaction
	typedef struct {
		logic                    granted;
		logic [OUT_TICKET_W-1:0] ticket;
		logic                    overflow;
	} lock_result_t;

	// bakery lock state mirror and queue of expected results
	class bakery_scoreboard;
		bit                  wanting_q[REQ_COUNT];
		logic [TICKET_W-1:0] tickets_q[REQ_COUNT];
		lock_result_t        awaited[$];
		int                  mismatches;

		function new();
			foreach (wanting_q[k]) begin
				wanting_q[k] = 1'b0;
				tickets_q[k] = '0;
			end
			mismatches = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function logic [TICKET_W-1:0] largest_ticket();
			logic [TICKET_W-1:0] top;
			top = '0;
			foreach (tickets_q[k])
				if (tickets_q[k] > top)
					top = tickets_q[k];
			return top;
		endfunction

		// wanting and nobody flagged holds a smaller ticket, ties broken by index
		function bit may_enter(int me);
			if (!wanting_q[me])
				return 1'b0;
			for (int k = 0; k < REQ_COUNT; k++) begin
				if (wanting_q[k] && (tickets_q[k] < tickets_q[me] ||
						(tickets_q[k] == tickets_q[me] && k < me)))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		// accepted request transaction: update the mirror, queue the result
		function void note_request(logic [CMD_W-1:0] c, logic [REQ_W-1:0] r);
			lock_result_t        res;
			logic [TICKET_W-1:0] top;
			int                  me;
			res.granted  = 1'b0;
			res.ticket   = '0;
			res.overflow = 1'b0;
			me = int'(r);
			if (me >= REQ_COUNT) begin
				awaited.push_back(res);
				return;
			end
			case (c)
				CMD_ACQUIRE: begin
					top = largest_ticket();
					wanting_q[me] = 1'b1;
					if (top == TICKET_TOP) begin
						tickets_q[me] = TICKET_TOP;
						res.overflow  = 1'b1;
					end else begin
						tickets_q[me] = top + 1'b1;
					end
					res.granted = may_enter(me);
				end
				CMD_RELEASE: begin
					wanting_q[me] = 1'b0;
				end
				default: begin
					res.granted = may_enter(me);
				end
			endcase
			res.ticket = OUT_TICKET_W'(tickets_q[me]);
			awaited.push_back(res);
		endfunction

		task report_mismatch(string what);
			if (mismatches < REPORT_LINES)
				$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// accepted result transaction against the oldest expectation
		task check_result(logic g, logic [OUT_TICKET_W-1:0] t, logic ov);
			lock_result_t res;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result granted=%b ticket=%0d ovf=%b",
					g, t, ov));
				return;
			end
			res = awaited.pop_front();
			if (g !== res.granted)
				report_mismatch($sformatf("granted %b, want %b", g, res.granted));
			if (t !== res.ticket)
				report_mismatch($sformatf("ticket %0d, want %0d", t, res.ticket));
			if (ov !== res.overflow)
				report_mismatch($sformatf("ticket_overflow %b, want %b", ov, res.overflow));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        cmd = CMD_POLL;
	logic [REQ_W-1:0]        requester = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    granted;
	logic [OUT_TICKET_W-1:0] ticket;
	logic                    ticket_overflow;

	bakery_scoreboard lock_sb = new();

	bakery_lock_arbiter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.requester       (requester),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted         (granted),
		.ticket          (ticket),
		.ticket_overflow (ticket_overflow)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle stretch length: mostly short, now and then long
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3);
		else if (pick < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sender gap after a transaction, zero most of the time
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	// command mix leaning toward acquire/poll/release cycles, a few spare codes
	function automatic logic [CMD_W-1:0] pick_cmd();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return CMD_ACQUIRE;
		else if (pick < 70)
			return CMD_POLL;
		else if (pick < 94)
			return CMD_RELEASE;
		return CMD_SPARE;
	endfunction

	// offer one request transaction, hold it until taken, then maybe go idle
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [REQ_W-1:0] r,
			input int gap);
		in_valid  <= 1'b1;
		cmd       <= c;
		requester <= r;
		do
			@(posedge clk);
		while (!in_ready);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (lock_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// watch both channels; inputs change only after the edge, so values are stable
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				lock_sb.note_request(cmd, requester);
			if (out_valid && out_ready)
				lock_sb.check_result(granted, ticket, ticket_overflow);
		end
	end

	// result side back-pressure, with one long hold-off to fill the block
	initial begin
		int rx_cycle;
		int stall_left;
		rx_cycle   = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == HOLD_AT_CYCLE) begin
				// sender keeps offering while results back up
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ((rx_cycle % 1000) < 150) begin
				// stretches with no stalls at all
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall_left = idle_len();
			end
		end
	end

	// stimulus
	initial begin
		logic [REQ_W-1:0]    pool[3];
		logic [REQ_W-1:0]    who;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first ticket, ordering, spare code, idle requester, own old ticket
		send_item(CMD_POLL,    3'd0, pick_gap());   // nobody wanting yet
		send_item(CMD_ACQUIRE, 3'd0, pick_gap());   // first ticket, granted
		send_item(CMD_POLL,    3'd0, pick_gap());
		send_item(CMD_ACQUIRE, 3'd7, pick_gap());   // behind requester 0
		send_item(CMD_POLL,    3'd7, pick_gap());
		send_item(CMD_SPARE,   3'd7, pick_gap());   // spare code acts as poll
		send_item(CMD_RELEASE, 3'd0, pick_gap());   // ticket kept, grant dropped
		send_item(CMD_POLL,    3'd0, pick_gap());   // not wanting
		send_item(CMD_POLL,    3'd7, pick_gap());   // now first in line
		send_item(CMD_RELEASE, 3'd3, pick_gap());   // release without acquire
		send_item(CMD_ACQUIRE, 3'd7, pick_gap());   // re-acquire above own ticket
		send_item(CMD_ACQUIRE, 3'd5, pick_gap());
		send_item(CMD_ACQUIRE, 3'd2, pick_gap());
		send_item(CMD_SPARE,   3'd2, pick_gap());
		send_item(CMD_RELEASE, 3'd7, pick_gap());
		send_item(CMD_POLL,    3'd5, pick_gap());   // handed over to 5
		send_item(CMD_POLL,    3'd2, pick_gap());
		for (int k = 0; k < REQ_COUNT; k++)
			send_item(CMD_RELEASE, REQ_W'(k), 0);

		// random: contention among a small rotating group, some stray requesters
		foreach (pool[k])
			pool[k] = REQ_W'($urandom_range(0, 7));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				foreach (pool[k])
					pool[k] = REQ_W'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 70)
				who = pool[$urandom_range(0, 2)];
			else
				who = REQ_W'($urandom_range(0, 7));
			send_item(pick_cmd(), who, (n % 200 < 40) ? 0 : pick_gap());
		end

		in_valid <= 1'b0;
		wait_idle();
		if (lock_sb.mismatches == 0 && lock_sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#100000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
